>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/bpd_pkg.sv
package bpd_pkg;

  // Framing bytes, row codes, row lengths and the multi-byte threshold
  localparam logic [7:0] SYNC_BYTE       = 8'hAA;
  localparam logic [7:0] EXCODE_BYTE     = 8'h55;
  localparam logic [7:0] MULTI_THRESHOLD = 8'd127;
  localparam logic [7:0] CODE_POOR       = 8'd2;
  localparam logic [7:0] CODE_ATTENTION  = 8'd4;
  localparam logic [7:0] CODE_MEDITATION = 8'd5;
  localparam logic [7:0] CODE_RAW        = 8'd128;
  localparam logic [7:0] CODE_BANDS      = 8'd131;
  localparam logic [7:0] RAW_LEN         = 8'd2;
  localparam logic [7:0] BANDS_LEN       = 8'd24;

  localparam int unsigned VALUE_W = 25;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CSUM_ERR   = 3'd0,
    KIND_LEN_ERR    = 3'd1,
    KIND_RAW        = 3'd2,
    KIND_POOR       = 3'd3,
    KIND_ATTENTION  = 3'd4,
    KIND_MEDITATION = 3'd5,
    KIND_BANDS      = 3'd6
  } kind_e;

  // Framing and payload-walk sequencer
  typedef enum logic [11:0] {
    S_SYNC1   = 12'b0000_0000_0001,
    S_SYNC2   = 12'b0000_0000_0010,
    S_LEN     = 12'b0000_0000_0100,
    S_DATA    = 12'b0000_0000_1000,
    S_CSUM    = 12'b0000_0001_0000,
    W_CODE_RD = 12'b0000_0010_0000,
    W_CODE    = 12'b0000_0100_0000,
    W_VLEN_RD = 12'b0000_1000_0000,
    W_VLEN    = 12'b0001_0000_0000,
    W_CHK     = 12'b0010_0000_0000,
    W_VAL_RD  = 12'b0100_0000_0000,
    W_VAL     = 12'b1000_0000_0000
  } state_e;

endpackage

>>> sv/biosensor_packet_deframer_unit.sv
// Biosensor packet deframer.
// Request channel: rx_byte_i is taken at a rising edge where start_i is high
// and busy_o is low. Sync, length and payload bytes leave busy_o low; a bad
// checksum or an oversized length gives one error result on the cycle after
// the byte.
// A checksum byte that matches starts a walk of the stored payload. The walk
// reads the payload memory through its single registered read port, with a
// read state and then a use state for each byte that it reads, plus a check
// state per row and a closing step (value bytes of skipped rows are not
// read); busy_o stays high throughout the walk.
// Results come out on result_strobe_o for one cycle each, in packet order,
// with last_o on the final result that the byte causes; a walk that finds no
// record gives no result. Each result is held back one step so that last_o
// is known, so the final one comes out in the cycle in which busy_o falls.
// The receiver cannot stall: results are never held off.
// Reset returns the block to hunting the first sync byte with no pending
// result; the payload memory is not cleared, since a walk only reads bytes
// written in the same packet.
module biosensor_packet_deframer_unit
  import bpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      result_strobe_o,
  output logic [2:0]                result_kind_o,
  output logic signed [VALUE_W-1:0] result_value_o,
  output logic [2:0]                band_index_o,
  output logic                      last_o
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned IW = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [7:0]  DEPTH_B = 8'(PAYLOAD_DEPTH);

  // Control registers
  state_e          state_q, state_d;
  logic [IW-1:0]   len_q, len_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            pend_vld_q, pend_vld_d;
  logic            strobe_q, strobe_d;

  // Datapath registers
  logic [7:0]      code_q, code_d;
  logic [7:0]      vlen_q, vlen_d;
  logic [1:0]      grp_sz_q, grp_sz_d;
  logic [1:0]      grp_cnt_q, grp_cnt_d;
  logic [2:0]      band_q, band_d;
  logic [23:0]     acc_q, acc_d;
  kind_e           row_kind_q, row_kind_d;
  kind_e           pend_kind_q, pend_kind_d;
  logic [VALUE_W-1:0] pend_val_q, pend_val_d;
  logic [2:0]      pend_band_q, pend_band_d;
  kind_e           out_kind_q, out_kind_d;
  logic [VALUE_W-1:0] out_val_q, out_val_d;
  logic [2:0]      out_band_q, out_band_d;
  logic            out_last_q, out_last_d;

  // Payload memory
  logic [7:0]      mem_q [PAYLOAD_DEPTH];
  logic [7:0]      rd_q;
  logic            wr_en;

  logic            accept;
  logic            walking;
  logic [IW-1:0]   idx_step;
  logic [IW-1:0]   add_b;
  logic [7:0]      room;
  logic [IW-1:0]   cnt_inc;
  logic [7:0]      sum_inc;

  assign walking = (state_q == W_CODE_RD) || (state_q == W_CODE) ||
                   (state_q == W_VLEN_RD) || (state_q == W_VLEN) ||
                   (state_q == W_CHK) || (state_q == W_VAL_RD) ||
                   (state_q == W_VAL);
  assign busy_o  = walking;
  assign accept  = start_i && !walking;
  assign wr_en   = accept && (state_q == S_DATA);

  // Shared index adder: one step or a whole skipped row
  assign add_b    = (state_q == W_CHK) ? IW'(vlen_q) : IW'(1);
  assign idx_step = idx_q + add_b;
  assign room     = 8'(len_q - idx_q);
  assign cnt_inc  = cnt_q + IW'(1);
  assign sum_inc  = sum_q + rx_byte_i;

  // Memory: one write port for bytes, one registered read at the walk index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= rx_byte_i;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  // Value of a finished record
  function automatic logic [VALUE_W-1:0] rec_value(kind_e k, logic [23:0] a);
    logic [VALUE_W-1:0] v;
    case (k)
      KIND_RAW:   v = {{(VALUE_W-16){a[15]}}, a[15:0]};
      KIND_BANDS: v = {{(VALUE_W-24){1'b0}}, a};
      default:    v = {{(VALUE_W-8){1'b0}}, a[7:0]};
    endcase
    return v;
  endfunction

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    pend_vld_d  = pend_vld_q;
    strobe_d    = 1'b0;
    code_d      = code_q;
    vlen_d      = vlen_q;
    grp_sz_d    = grp_sz_q;
    grp_cnt_d   = grp_cnt_q;
    band_d      = band_q;
    acc_d       = acc_q;
    row_kind_d  = row_kind_q;
    pend_kind_d = pend_kind_q;
    pend_val_d  = pend_val_q;
    pend_band_d = pend_band_q;
    out_kind_d  = out_kind_q;
    out_val_d   = out_val_q;
    out_band_d  = out_band_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_SYNC1: begin
        if (accept) begin
          state_d = (rx_byte_i == SYNC_BYTE) ? S_SYNC2 : S_SYNC1;
        end
      end

      S_SYNC2: begin
        if (accept) begin
          state_d = (rx_byte_i == SYNC_BYTE) ? S_LEN : S_SYNC1;
        end
      end

      S_LEN: begin
        if (accept) begin
          if (rx_byte_i > DEPTH_B) begin
            // oversized packet: one error result
            strobe_d   = 1'b1;
            out_kind_d = KIND_LEN_ERR;
            out_val_d  = '0;
            out_band_d = '0;
            out_last_d = 1'b1;
            state_d    = S_SYNC1;
          end else begin
            len_d   = IW'(rx_byte_i);
            cnt_d   = '0;
            sum_d   = '0;
            state_d = (rx_byte_i == 8'd0) ? S_CSUM : S_DATA;
          end
        end
      end

      S_DATA: begin
        if (accept) begin
          cnt_d = cnt_inc;
          sum_d = sum_inc;
          if (cnt_inc >= len_q) begin
            state_d = S_CSUM;
          end
        end
      end

      S_CSUM: begin
        if (accept) begin
          if (rx_byte_i != ~sum_q) begin
            strobe_d   = 1'b1;
            out_kind_d = KIND_CSUM_ERR;
            out_val_d  = '0;
            out_band_d = '0;
            out_last_d = 1'b1;
            state_d    = S_SYNC1;
          end else begin
            idx_d      = '0;
            pend_vld_d = 1'b0;
            state_d    = W_CODE_RD;
          end
        end
      end

      // Fetch the next code byte, or close the walk at the payload end
      W_CODE_RD: begin
        if (idx_q >= len_q) begin
          strobe_d   = pend_vld_q;
          out_kind_d = pend_kind_q;
          out_val_d  = pend_val_q;
          out_band_d = pend_band_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_SYNC1;
        end else begin
          state_d = W_CODE;
        end
      end

      W_CODE: begin
        idx_d = idx_step;
        if (rd_q == EXCODE_BYTE) begin
          state_d = W_CODE_RD;
        end else begin
          code_d = rd_q;
          vlen_d = 8'd1;
          if (rd_q > MULTI_THRESHOLD) begin
            if (idx_step >= len_q) begin
              // length byte runs past the end
              strobe_d   = pend_vld_q;
              out_kind_d = pend_kind_q;
              out_val_d  = pend_val_q;
              out_band_d = pend_band_q;
              out_last_d = 1'b1;
              pend_vld_d = 1'b0;
              state_d    = S_SYNC1;
            end else begin
              state_d = W_VLEN_RD;
            end
          end else begin
            state_d = W_CHK;
          end
        end
      end

      W_VLEN_RD: begin
        state_d = W_VLEN;
      end

      W_VLEN: begin
        vlen_d  = rd_q;
        idx_d   = idx_step;
        state_d = W_CHK;
      end

      // Row check and dispatch
      W_CHK: begin
        grp_cnt_d = '0;
        band_d    = '0;
        if (vlen_q > room) begin
          // truncated row
          strobe_d   = pend_vld_q;
          out_kind_d = pend_kind_q;
          out_val_d  = pend_val_q;
          out_band_d = pend_band_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_SYNC1;
        end else if (code_q == CODE_RAW && vlen_q == RAW_LEN) begin
          row_kind_d = KIND_RAW;
          grp_sz_d   = 2'd2;
          state_d    = W_VAL_RD;
        end else if (code_q == CODE_BANDS && vlen_q == BANDS_LEN) begin
          row_kind_d = KIND_BANDS;
          grp_sz_d   = 2'd3;
          state_d    = W_VAL_RD;
        end else if (code_q == CODE_POOR) begin
          row_kind_d = KIND_POOR;
          grp_sz_d   = 2'd1;
          state_d    = W_VAL_RD;
        end else if (code_q == CODE_ATTENTION) begin
          row_kind_d = KIND_ATTENTION;
          grp_sz_d   = 2'd1;
          state_d    = W_VAL_RD;
        end else if (code_q == CODE_MEDITATION) begin
          row_kind_d = KIND_MEDITATION;
          grp_sz_d   = 2'd1;
          state_d    = W_VAL_RD;
        end else begin
          // unknown row or wrong length: skip its value bytes
          idx_d   = idx_step;
          state_d = W_CODE_RD;
        end
      end

      W_VAL_RD: begin
        state_d = W_VAL;
      end

      // Shift in one value byte; a full group makes a record
      W_VAL: begin
        acc_d     = {acc_q[15:0], rd_q};
        idx_d     = idx_step;
        vlen_d    = vlen_q - 8'd1;
        grp_cnt_d = grp_cnt_q + 2'd1;
        if (grp_cnt_q + 2'd1 == grp_sz_q) begin
          grp_cnt_d = '0;
          band_d    = band_q + 3'd1;
          // the held record is not the last one: send it now
          strobe_d    = pend_vld_q;
          out_kind_d  = pend_kind_q;
          out_val_d   = pend_val_q;
          out_band_d  = pend_band_q;
          out_last_d  = 1'b0;
          pend_vld_d  = 1'b1;
          pend_kind_d = row_kind_q;
          pend_val_d  = rec_value(row_kind_q, {acc_q[15:0], rd_q});
          pend_band_d = (row_kind_q == KIND_BANDS) ? band_q : 3'd0;
        end
        state_d = (vlen_q == 8'd1) ? W_CODE_RD : W_VAL_RD;
      end

      default: begin
        state_d = S_SYNC1;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SYNC1;
      len_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    vlen_q      <= vlen_d;
    grp_sz_q    <= grp_sz_d;
    grp_cnt_q   <= grp_cnt_d;
    band_q      <= band_d;
    acc_q       <= acc_d;
    row_kind_q  <= row_kind_d;
    pend_kind_q <= pend_kind_d;
    pend_val_q  <= pend_val_d;
    pend_band_q <= pend_band_d;
    out_kind_q  <= out_kind_d;
    out_val_q   <= out_val_d;
    out_band_q  <= out_band_d;
    out_last_q  <= out_last_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_kind_o   = out_kind_q;
  assign result_value_o  = out_val_q;
  assign band_index_o    = out_band_q;
  assign last_o          = out_last_q;

  // Checks
  `include "assert_macros.svh"

  // a result that is not the last one only leaves while the walk runs
  `ASSERT_IMPL(a_more_follows, clk_i, rst_ni, result_strobe_o && !last_o, busy_o)
  `ASSERT_IMPL(a_no_pend_idle, clk_i, rst_ni, !busy_o, !pend_vld_q)
  `ASSERT_IMPL(a_idx_in_pkt, clk_i, rst_ni, busy_o, idx_q <= len_q)
  `ASSERT_IMPL(a_band_kind, clk_i, rst_ni, result_strobe_o && band_index_o != 3'd0,
               result_kind_o == KIND_BANDS)

endmodule
